// ----- src/mrfc_pkg.sv -----
// ----------------------------------------------------------------------------
// mrfc_pkg
// Shared types and constants for the modulated reciprocal frequency counter.
// ----------------------------------------------------------------------------
package mrfc_pkg;

    // Default values for the top-level parameters
    localparam int DEF_CAPTURE_PRESCALE = 8;
    localparam int DEF_OUTPUT_DIVISION  = 16;
    localparam int DEF_DAC_MIDSCALE     = 2048;

    // Field widths
    localparam int REQ_W    = 2;
    localparam int TIME_W   = 16;
    localparam int DAC_W    = 12;
    localparam int RES_W    = 32;
    localparam int CPR_W    = 16;
    localparam int RP_W     = 8;
    localparam int REF_W    = 26;
    localparam int TLIM_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 26;

    // Stream packing
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 3;
    localparam int M_FIELD_W = DAC_W + 2 * RES_W;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_START   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CAPTURE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_ROUND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_PAIRS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULATION_SPAN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_FREQUENCY_HZ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT_MS    = 3'd4;

    // Controller -> datapath
    typedef struct packed {
        logic process;       // apply the held input item to the state
        logic load_nf;       // load a non-final result into the output register
        logic mul1;          // cycles_per_round * round_pairs
        logic mul2;          // times the fixed scale, arm the serial multiplier
        logic ser_step;      // one shift-add step
        logic div_load_dev;  // arm the divider for the deviation
        logic div_load_frq;  // park deviation quotient, arm for frequency
        logic div_step;      // one restoring-division step
        logic load_final;    // load the final result into the output register
    } mrfc_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic in_full;
        logic out_free;
        logic item_emits;
        logic item_final;
        logic ser_last;
        logic div_last;
    } mrfc_status_t;

endpackage

// ----- src/mrfc_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrfc_ctrl
// Sequencer: item processing and the final multiply / divide schedule.
// ----------------------------------------------------------------------------
module mrfc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mrfc_pkg::mrfc_status_t status,
    output mrfc_pkg::mrfc_cmd_t    cmd
);
    import mrfc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MUL1   = 8'b0000_0010,
        ST_MUL2   = 8'b0000_0100,
        ST_MULSER = 8'b0000_1000,
        ST_DIVDEV = 8'b0001_0000,
        ST_LDFRQ  = 8'b0010_0000,
        ST_DIVFRQ = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.in_full && status.out_free)
                begin
                    cmd.process = 1'b1;
                    if (status.item_final)
                        state_next = ST_MUL1;
                    else if (status.item_emits)
                        cmd.load_nf = 1'b1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_MULSER;
            end
            ST_MULSER:
            begin
                cmd.ser_step = 1'b1;
                if (status.ser_last)
                begin
                    cmd.div_load_dev = 1'b1;
                    state_next       = ST_DIVDEV;
                end
            end
            ST_DIVDEV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_LDFRQ;
            end
            ST_LDFRQ:
            begin
                cmd.div_load_frq = 1'b1;
                state_next       = ST_DIVFRQ;
            end
            ST_DIVFRQ:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- src/mrfc_dpath.sv -----
// ----------------------------------------------------------------------------
// mrfc_dpath
// Input/output registers, configuration, measurement state, serial
// multiplier and shared restoring divider.
// ----------------------------------------------------------------------------
module mrfc_dpath #(
    parameter int CAPTURE_PRESCALE = mrfc_pkg::DEF_CAPTURE_PRESCALE,
    parameter int OUTPUT_DIVISION  = mrfc_pkg::DEF_OUTPUT_DIVISION,
    parameter int DAC_MIDSCALE     = mrfc_pkg::DEF_DAC_MIDSCALE
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mrfc_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [mrfc_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mrfc_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [mrfc_pkg::M_TUSER_W-1:0]     m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mrfc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mrfc_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  mrfc_pkg::mrfc_cmd_t                cmd,
    output mrfc_pkg::mrfc_status_t             status
);
    import mrfc_pkg::*;

    // Fixed scale 2 * prescale * division, and the widths that follow from it
    localparam int KMUL = 2 * CAPTURE_PRESCALE * OUTPUT_DIVISION;
    localparam int KW   = $clog2(KMUL + 1);
    localparam int P1W  = CPR_W + RP_W;
    localparam int MW   = P1W + KW;
    localparam int NUMW = MW + REF_W;
    localparam int DEVW = 2 * RES_W - 2;              // |diff| << 30
    localparam int DVW  = (NUMW > DEVW) ? NUMW : DEVW;
    localparam int CNTW = $clog2(DVW);
    localparam logic signed [14:0] MID_S = 15'(DAC_MIDSCALE);

    // ---------------- configuration ----------------
    logic [CPR_W-1:0]  cpr_reg;
    logic [RP_W-1:0]   rp_reg;
    logic [DAC_W-1:0]  span_reg;
    logic [REF_W-1:0]  ref_reg;
    logic [TLIM_W-1:0] tlim_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg  <= 16'd800;
            rp_reg   <= 8'd1;
            span_reg <= '0;
            ref_reg  <= 26'd16000000;
            tlim_reg <= 16'd5000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CYCLES_PER_ROUND: cpr_reg  <= cfg_data[CPR_W-1:0];
                CFG_ROUND_PAIRS:      rp_reg   <= cfg_data[RP_W-1:0];
                CFG_MODULATION_SPAN:  span_reg <= cfg_data[DAC_W-1:0];
                CFG_REF_FREQUENCY_HZ: ref_reg  <= cfg_data[REF_W-1:0];
                CFG_TIME_LIMIT_MS:    tlim_reg <= cfg_data[TLIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input holding register ----------------
    logic              in_full_reg;
    logic [REQ_W-1:0]  in_req_reg;
    logic [TIME_W-1:0] in_time_reg;

    assign s_tready = !in_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_full_reg <= 1'b1;
        else if (cmd.process)
            in_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg  <= s_tuser;
            in_time_reg <= s_tdata[TIME_W-1:0];
        end
    end

    // ---------------- measurement state ----------------
    logic [16:0]       ic_reg,  ic_next;
    logic [TIME_W-1:0] last_reg, last_next;
    logic [31:0]       rs_reg,  rs_next;
    logic [31:0]       low_reg, low_next;
    logic [31:0]       high_reg, high_next;
    logic [31:0]       grand_reg, grand_next;
    logic              hp_reg,  hp_next;
    logic [8:0]        rd_reg,  rd_next;
    logic [15:0]       el_reg,  el_next;
    logic              run_reg, run_next;
    logic              set_reg, set_next;
    logic              fin_upd_reg, fin_upd_next;
    logic              fin_ok_reg,  fin_ok_next;

    logic              it_emit, it_final;
    logic [16:0]       ic_a;
    logic [31:0]       rs_a;
    logic [8:0]        rd_a;
    logic [15:0]       el_a;
    logic [TIME_W-1:0] diff;

    always_comb
    begin
        ic_next      = ic_reg;
        last_next    = last_reg;
        rs_next      = rs_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        grand_next   = grand_reg;
        hp_next      = hp_reg;
        rd_next      = rd_reg;
        el_next      = el_reg;
        run_next     = run_reg;
        set_next     = set_reg;
        fin_upd_next = fin_upd_reg;
        fin_ok_next  = fin_ok_reg;
        it_emit      = 1'b0;
        it_final     = 1'b0;
        ic_a         = ic_reg;
        rs_a         = rs_reg;
        rd_a         = rd_reg + 9'd1;
        el_a         = (el_reg != 16'hFFFF) ? el_reg + 16'd1 : el_reg;
        diff         = in_time_reg - last_reg;

        case (in_req_reg)
            REQ_START:
            begin
                ic_next    = '0;
                last_next  = '0;
                rs_next    = '0;
                low_next   = '0;
                high_next  = '0;
                grand_next = '0;
                hp_next    = 1'b0;
                rd_next    = '0;
                el_next    = '0;
                run_next   = 1'b1;
                set_next   = 1'b1;
                it_emit    = 1'b1;
                if (rp_reg == '0)
                begin
                    run_next     = 1'b0;
                    it_final     = 1'b1;
                    fin_upd_next = 1'b1;
                    fin_ok_next  = 1'b1;
                end
                else if (tlim_reg == '0)
                begin
                    run_next     = 1'b0;
                    it_final     = 1'b1;
                    fin_upd_next = 1'b1;
                    fin_ok_next  = 1'b0;
                end
            end
            REQ_TICK:
            begin
                if (run_reg)
                begin
                    set_next = 1'b0;
                    el_next  = el_a;
                    if (el_a >= tlim_reg)
                    begin
                        run_next     = 1'b0;
                        it_emit      = 1'b1;
                        it_final     = 1'b1;
                        fin_upd_next = 1'b0;
                        fin_ok_next  = 1'b0;
                    end
                end
            end
            REQ_CAPTURE:
            begin
                if (run_reg && !set_reg)
                begin
                    if (ic_reg == '0)
                    begin
                        last_next = in_time_reg;
                        ic_a      = 17'd1;
                    end
                    else if (ic_reg <= {1'b0, cpr_reg})
                    begin
                        rs_a      = rs_reg + {16'b0, diff};
                        last_next = in_time_reg;
                        ic_a      = ic_reg + 17'd1;
                    end
                    ic_next = ic_a;
                    rs_next = rs_a;
                    if (ic_a > {1'b0, cpr_reg})
                    begin
                        // round complete
                        if (hp_reg)
                            high_next = high_reg + rs_a;
                        else
                            low_next = low_reg + rs_a;
                        grand_next = grand_reg + rs_a;
                        hp_next    = !hp_reg;
                        rd_next    = rd_a;
                        ic_next    = '0;
                        rs_next    = '0;
                        it_emit    = 1'b1;
                        if (rd_a == {rp_reg, 1'b0})
                        begin
                            run_next     = 1'b0;
                            it_final     = 1'b1;
                            fin_upd_next = 1'b1;
                            fin_ok_next  = 1'b1;
                        end
                        else
                            set_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_reg      <= '0;
            last_reg    <= '0;
            rs_reg      <= '0;
            low_reg     <= '0;
            high_reg    <= '0;
            grand_reg   <= '0;
            hp_reg      <= 1'b0;
            rd_reg      <= '0;
            el_reg      <= '0;
            run_reg     <= 1'b0;
            set_reg     <= 1'b0;
            fin_upd_reg <= 1'b0;
            fin_ok_reg  <= 1'b0;
        end
        else if (cmd.process)
        begin
            ic_reg      <= ic_next;
            last_reg    <= last_next;
            rs_reg      <= rs_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            grand_reg   <= grand_next;
            hp_reg      <= hp_next;
            rd_reg      <= rd_next;
            el_reg      <= el_next;
            run_reg     <= run_next;
            set_reg     <= set_next;
            fin_upd_reg <= fin_upd_next;
            fin_ok_reg  <= fin_ok_next;
        end
    end

    // ---------------- DAC code ----------------
    logic                    dac_hp;
    logic signed [14:0]      dac_base, dac_s;
    logic [DAC_W-1:0]        dac_code;

    always_comb
    begin
        dac_hp   = cmd.process ? hp_next : hp_reg;
        dac_base = MID_S - $signed({4'b0, span_reg[DAC_W-1:1]});
        dac_s    = dac_hp ? dac_base + $signed({3'b0, span_reg}) : dac_base;
        if (dac_s < 15'sd0)
            dac_code = '0;
        else if (dac_s > 15'sd4095)
            dac_code = 12'hFFF;
        else
            dac_code = dac_s[DAC_W-1:0];
    end

    // ---------------- numerator: serial shift-add multiplier ----------------
    logic [P1W-1:0]    p1_reg;
    logic [MW-1:0]     m2;
    logic [NUMW-1:0]   mcand_reg;
    logic [NUMW-1:0]   acc_reg;
    logic [REF_W-1:0]  refsh_reg;
    logic [CNTW-1:0]   cnt_reg;

    assign m2 = MW'(p1_reg) * MW'(KMUL);

    // ---------------- shared restoring divider ----------------
    logic [31:0]       dd, den_sum, mag;
    logic              neg;
    logic [DVW-1:0]    dq_reg, devq_reg;
    logic [31:0]       rem_reg, den_reg;
    logic [32:0]       trial;
    logic              ge;

    always_comb
    begin
        dd      = low_reg - high_reg;
        den_sum = low_reg + high_reg;
        neg     = dd[31];
        mag     = neg ? 32'd0 - dd : dd;
        trial   = {rem_reg, dq_reg[DVW-1]};
        ge      = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.mul2 || cmd.div_load_dev || cmd.div_load_frq)
            cnt_reg <= '0;
        else if (cmd.ser_step || cmd.div_step)
            cnt_reg <= cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
            p1_reg <= P1W'(cpr_reg) * P1W'(rp_reg);
        if (cmd.mul2)
        begin
            mcand_reg <= NUMW'(m2);
            refsh_reg <= ref_reg;
            acc_reg   <= '0;
        end
        else if (cmd.ser_step)
        begin
            if (refsh_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg <= mcand_reg << 1;
            refsh_reg <= refsh_reg >> 1;
        end

        if (cmd.div_load_dev)
        begin
            dq_reg  <= DVW'({mag, 30'b0});
            den_reg <= den_sum;
            rem_reg <= '0;
        end
        else if (cmd.div_load_frq)
        begin
            devq_reg <= dq_reg;
            dq_reg   <= DVW'(acc_reg);
            den_reg  <= grand_reg;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
            dq_reg  <= {dq_reg[DVW-2:0], ge};
        end
    end

    // ---------------- final result shaping ----------------
    logic [RES_W-1:0] dev_res, frq_res;

    always_comb
    begin
        if (den_sum == '0)
            dev_res = '0;
        else if (neg)
            dev_res = (devq_reg > DVW'(32'h8000_0000)) ? 32'h8000_0000
                                                      : 32'd0 - devq_reg[31:0];
        else
            dev_res = (devq_reg > DVW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                      : devq_reg[31:0];

        if (grand_reg == '0)
            frq_res = '0;
        else if (|dq_reg[DVW-1:RES_W])
            frq_res = 32'hFFFF_FFFF;
        else
            frq_res = dq_reg[RES_W-1:0];
    end

    // ---------------- output register ----------------
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TUSER_W-1:0]  m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.load_nf || cmd.load_final)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_nf)
        begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, {RES_W{1'b0}}, {RES_W{1'b0}}, dac_code};
            m_tuser_reg <= 3'b001;
        end
        else if (cmd.load_final)
        begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, frq_res, dev_res, dac_code};
            m_tuser_reg <= {fin_ok_reg, 1'b1, fin_upd_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------- status ----------------
    always_comb
    begin
        status.in_full    = in_full_reg;
        status.out_free   = !m_tvalid_reg || m_tready;
        status.item_emits = it_emit;
        status.item_final = it_final;
        status.ser_last   = (cnt_reg == CNTW'(REF_W - 1));
        status.div_last   = (cnt_reg == CNTW'(DVW - 1));
    end

endmodule

// ----- src/modulated_reciprocal_freq_counter_top.sv -----
// ----------------------------------------------------------------------------
// modulated_reciprocal_freq_counter_top
// Reciprocal frequency counter with low/high DAC modulation rounds.
// ----------------------------------------------------------------------------
//
//  channel | direction | signals                         | content
//  --------+-----------+---------------------------------+--------------------------
//  s_*     | in        | s_tvalid/s_tready/s_tdata/s_tuser | request kind + timestamp
//  m_*     | out       | m_tvalid/m_tready/m_tdata/m_tuser | DAC code, flags, results
//  cfg_*   | in        | cfg_valid/cfg_ready/cfg_index/cfg_data | register writes
//
//  A start, capture or tick transaction is applied from the input register
//  once the result side is free; no new item is taken while one is held.
//  A measurement end runs the product cycles_per_round * round_pairs, its
//  product with the fixed scale, a 26-step shift-add multiplier, two passes
//  of the 62-step restoring divider around a reload, and the output load.
//  rst_n clears all control state asynchronously and loads register defaults.
//  A stalled m_* side holds its result; one more item is taken meanwhile and
//  parked in the input register. cfg_ready is always high.
//
module modulated_reciprocal_freq_counter_top #(
    parameter int CAPTURE_PRESCALE = mrfc_pkg::DEF_CAPTURE_PRESCALE,
    parameter int OUTPUT_DIVISION  = mrfc_pkg::DEF_OUTPUT_DIVISION,
    parameter int DAC_MIDSCALE     = mrfc_pkg::DEF_DAC_MIDSCALE
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mrfc_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] capture_time
    input  logic [mrfc_pkg::S_TUSER_W-1:0] s_tuser,   // [1:0] req_type
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mrfc_pkg::M_TDATA_W-1:0] m_tdata,   // [11:0] dac_value,
                                                      // [43:12] deviation,
                                                      // [75:44] frequency_hz,
                                                      // [79:76] zero
    output logic [mrfc_pkg::M_TUSER_W-1:0] m_tuser,   // [0] dac_update,
                                                      // [1] done_res, [2] success
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mrfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mrfc_pkg::CFG_DAT_W-1:0] cfg_data
);
    import mrfc_pkg::*;

    mrfc_cmd_t    cmd;
    mrfc_status_t status;

    // Sequencer: decides when the held item is applied and steps the
    // multiply/divide schedule at the end of a measurement.
    mrfc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // Datapath: all state, arithmetic and the stream registers.
    mrfc_dpath #(
        .CAPTURE_PRESCALE (CAPTURE_PRESCALE),
        .OUTPUT_DIVISION  (OUTPUT_DIVISION),
        .DAC_MIDSCALE     (DAC_MIDSCALE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- src/mrfc_checker.sv -----
// ----------------------------------------------------------------------------
// mrfc_checker
// Port-level checks for the frequency counter, bound to the top level.
// ----------------------------------------------------------------------------
module mrfc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mrfc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [mrfc_pkg::M_TUSER_W-1:0] m_tuser
);
    import mrfc_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // interim results carry no deviation or frequency
    a_interim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata[M_FIELD_W-1:DAC_W] == '0)
        else $error("interim result with nonzero measurement");

    // success only on a final result
    a_success_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1])
        else $error("success without done");

    // a successful end always sets a new DAC code
    a_success_upd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[0])
        else $error("successful end without DAC update");

    // padding stays zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:M_FIELD_W] == '0)
        else $error("tdata padding nonzero");

endmodule

bind modulated_reciprocal_freq_counter_top mrfc_checker u_mrfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- verif/tb_modulated_reciprocal_freq_counter_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modulated_reciprocal_freq_counter_top
// Self-checking bench for the modulated reciprocal frequency counter. A
// built-in predictor tracks rounds, phase sums and the final division, and
// every result transaction is compared field by field with it. Requests come
// in bursts with random gaps, the result side stalls on a rotating pattern,
// and the register set is changed between measurement phases.
// ----------------------------------------------------------------------------
module tb_modulated_reciprocal_freq_counter_top;
    import mrfc_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;  // no meaning, must be dropped
    localparam int CYCLE_LIMIT     = 5_000_000;
    localparam int SETTLE_CYCLES   = 200;           // covers the final multiply/divide math
    localparam int TARGET_REQUESTS = 1100;
    localparam int MAX_PRINTS      = 30;
    localparam int DAC_MAX         = (1 << DAC_W) - 1;

    // One result transaction, split into its fields
    typedef struct {
        logic [DAC_W-1:0] dac_value;
        logic             dac_update;
        logic             done_res;
        logic             success;
        logic [RES_W-1:0] deviation;
        logic [RES_W-1:0] frequency_hz;
    } counter_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts measurement results and checks them in order
    // ------------------------------------------------------------------------
    class freq_counter_scoreboard;
        // register copies
        bit [CPR_W-1:0]  cycles_per_round = 16'd800;
        bit [RP_W-1:0]   round_pairs      = 8'd1;
        bit [DAC_W-1:0]  span             = '0;
        bit [REF_W-1:0]  ref_hz           = 26'd16000000;
        bit [TLIM_W-1:0] limit_ms         = 16'd5000;
        // measurement state
        bit [16:0] interval_cnt;
        bit [15:0] last_stamp;
        bit [31:0] round_acc, low_acc, high_acc, total_acc;
        bit        high_phase;
        bit [8:0]  rounds_done;
        bit [15:0] elapsed_ms;
        bit        running, settling;
        counter_result_t expected_q[$];
        int mismatches, results_seen, finals_ok, finals_aborted;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
            case (idx)
                CFG_CYCLES_PER_ROUND: cycles_per_round = value[CPR_W-1:0];
                CFG_ROUND_PAIRS:      round_pairs      = value[RP_W-1:0];
                CFG_MODULATION_SPAN:  span             = value[DAC_W-1:0];
                CFG_REF_FREQUENCY_HZ: ref_hz           = value[REF_W-1:0];
                CFG_TIME_LIMIT_MS:    limit_ms         = value[TLIM_W-1:0];
                default: ;
            endcase
        endfunction

        // DAC code of the phase in force, clamped to the converter range
        function bit [DAC_W-1:0] dac_code();
            int v;
            v = DEF_DAC_MIDSCALE - int'(span >> 1);
            if (high_phase)
                v += int'(span);
            if (v < 0)
                v = 0;
            if (v > DAC_MAX)
                v = DAC_MAX;
            return v[DAC_W-1:0];
        endfunction

        function void push_result(bit upd, bit done, bit ok);
            counter_result_t r;
            bit [31:0] diff, den;
            bit [63:0] mag, quo, num;
            r.dac_value    = dac_code();
            r.dac_update   = upd;
            r.done_res     = done;
            r.success      = ok;
            r.deviation    = '0;
            r.frequency_hz = '0;
            if (done)
            begin
                // 2*(low-high)/(low+high) in Q2.29, truncated toward zero
                diff = low_acc - high_acc;
                den  = low_acc + high_acc;
                mag  = {32'd0, diff[31] ? 32'd0 - diff : diff};
                if (den != 0)
                begin
                    quo = (mag << 30) / {32'd0, den};
                    if (diff[31])
                    begin
                        if (quo > 64'h8000_0000)
                            quo = 64'h8000_0000;
                        r.deviation = 32'd0 - quo[31:0];
                    end
                    else
                    begin
                        if (quo > 64'h7FFF_FFFF)
                            quo = 64'h7FFF_FFFF;
                        r.deviation = quo[31:0];
                    end
                end
                if (total_acc != 0)
                begin
                    num = 64'(cycles_per_round) * 64'(2 * DEF_CAPTURE_PRESCALE)
                        * 64'(round_pairs) * 64'(ref_hz) * 64'(DEF_OUTPUT_DIVISION);
                    num = num / {32'd0, total_acc};
                    r.frequency_hz = (num > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : num[31:0];
                end
                if (ok)
                    finals_ok++;
                else
                    finals_aborted++;
            end
            expected_q.push_back(r);
        endfunction

        // Apply one accepted request; returns 1 if it had any effect
        function bit note_request(bit [REQ_W-1:0] kind, bit [TIME_W-1:0] stamp);
            if (kind == REQ_START)
            begin
                interval_cnt = '0;
                last_stamp   = '0;
                round_acc    = '0;
                low_acc      = '0;
                high_acc     = '0;
                total_acc    = '0;
                high_phase   = 1'b0;
                rounds_done  = '0;
                elapsed_ms   = '0;
                running      = 1'b1;
                settling     = 1'b1;
                if (round_pairs == 0)
                begin
                    running = 1'b0;
                    push_result(1'b1, 1'b1, 1'b1);
                end
                else if (limit_ms == 0)
                begin
                    running = 1'b0;
                    push_result(1'b1, 1'b1, 1'b0);
                end
                else
                    push_result(1'b1, 1'b0, 1'b0);
                return 1'b1;
            end
            if (!running)
                return 1'b0;
            if (kind == REQ_TICK)
            begin
                settling = 1'b0;
                if (elapsed_ms != 16'hFFFF)
                    elapsed_ms++;
                if (elapsed_ms >= limit_ms)
                begin
                    running = 1'b0;
                    push_result(1'b0, 1'b1, 1'b0);
                end
                return 1'b1;
            end
            if (kind != REQ_CAPTURE || settling)
                return 1'b0;

            // first capture of a round is only the baseline
            if (interval_cnt == 0)
            begin
                last_stamp   = stamp;
                interval_cnt = 17'd1;
            end
            else if (interval_cnt <= cycles_per_round)
            begin
                round_acc    += 32'(16'(stamp - last_stamp));
                last_stamp   = stamp;
                interval_cnt = interval_cnt + 17'd1;
            end
            if (interval_cnt <= cycles_per_round)
                return 1'b1;

            // round complete
            if (high_phase)
                high_acc += round_acc;
            else
                low_acc += round_acc;
            total_acc    += round_acc;
            high_phase   = ~high_phase;
            rounds_done  = rounds_done + 9'd1;
            interval_cnt = '0;
            round_acc    = '0;
            if (rounds_done == {round_pairs, 1'b0})
            begin
                running = 1'b0;
                push_result(1'b1, 1'b1, 1'b1);
            end
            else
            begin
                settling = 1'b1;
                push_result(1'b1, 1'b0, 1'b0);
            end
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_PRINTS)
                    $display("%0t: %s expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
            counter_result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_PRINTS)
                    $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
                             $time, data, user);
                return;
            end
            want = expected_q.pop_front();
            compare_field("dac_value", want.dac_value, data[DAC_W-1:0]);
            compare_field("deviation", want.deviation, data[DAC_W +: RES_W]);
            compare_field("frequency_hz", want.frequency_hz, data[DAC_W+RES_W +: RES_W]);
            compare_field("tdata pad", '0, data[M_TDATA_W-1:M_FIELD_W]);
            compare_field("dac_update", want.dac_update, user[0]);
            compare_field("done_res", want.done_res, user[1]);
            compare_field("success", want.success, user[2]);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;    // [15:0] capture_time
    logic [S_TUSER_W-1:0] s_tuser = '0;    // [1:0] req_type
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [11:0] dac_value, [43:12] deviation,
                                           // [75:44] frequency_hz, [79:76] zero
    logic [M_TUSER_W-1:0] m_tuser;         // [0] dac_update, [1] done_res, [2] success
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    modulated_reciprocal_freq_counter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    freq_counter_scoreboard sb = new();

    int        cycle_count = 0;
    int        burst_left = 0;       // transactions left in the current sender burst
    bit        steady_sender = 1'b0; // no gaps at all during this phase
    int        requests_sent = 0;    // every accepted request transaction
    int        requests_applied = 0; // requests that changed state or produced a result
    int        phases = 0;
    int        nominal_period = 2000;
    int        phase_shift = 0;      // extra period while the high DAC code is on
    bit [15:0] stamp_clock = '0;

    // 2 ns clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Result-side stall pattern, rotating with the cycle counter, plus the watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        case (cycle_count[11:10])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_tready <= (cycle_count[1:0] == 2'd0);
            default: m_tready <= (cycle_count[5:0] < 6'd8);   // long stalls
        endcase
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("modulated_reciprocal_freq_counter_top: mismatch");
            $finish;
        end
    end

    // Result monitor: values read here are the ones present at the edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One request transaction. tvalid is left high after acceptance so the next
    // burst member follows back to back; a gap or drain() lowers it.
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [TIME_W-1:0] stamp);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = steady_sender ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= stamp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
        if (sb.note_request(kind, stamp))
            requests_applied++;
    endtask

    // Register write; cfg_valid stays high for back-to-back writes
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task automatic write_config(input int cpr, input int pairs, input int span,
                                input int ref_hz, input int limit);
        put_reg(CFG_CYCLES_PER_ROUND, CFG_DAT_W'(cpr));
        put_reg(CFG_ROUND_PAIRS, CFG_DAT_W'(pairs));
        put_reg(CFG_MODULATION_SPAN, CFG_DAT_W'(span));
        put_reg(CFG_REF_FREQUENCY_HZ, CFG_DAT_W'(ref_hz));
        put_reg(CFG_TIME_LIMIT_MS, CFG_DAT_W'(limit));
        cfg_valid <= 1'b0;
        phases++;
    endtask

    // Stop sending, wait for every expected result, then let the block go quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Next capture timestamp: mostly a jittered period that differs between
    // the two DAC phases, sometimes a random or extreme jump
    function automatic bit [15:0] next_stamp();
        int pick;
        int delta;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            delta = nominal_period + (sb.high_phase ? phase_shift : 0) + $urandom_range(0, 15);
        else if (pick < 9)
            delta = $urandom_range(0, 65535);
        else
            delta = $urandom_range(0, 1) ? 0 : 65535;
        stamp_clock = stamp_clock + 16'(delta);
        return stamp_clock;
    endfunction

    // A measurement: start, then ticks and captures until it ends, with stray
    // ticks, ignored kinds, captures during settling and rare restarts mixed in
    task automatic run_measurement();
        int budget;
        int roll;
        budget = 0;
        send_request(REQ_START, 16'($urandom));
        while (sb.running)
        begin
            budget++;
            roll = $urandom_range(0, 399);
            if (budget > 600)
                send_request(REQ_TICK, 16'($urandom));      // run out the time limit
            else if (roll == 0)
                send_request(REQ_START, 16'($urandom));     // restart mid-measurement
            else if (roll < 12)
                send_request(REQ_UNUSED, 16'($urandom));
            else if (sb.settling)
            begin
                if (roll < 60)
                    send_request(REQ_CAPTURE, next_stamp());
                else
                    send_request(REQ_TICK, 16'($urandom));
            end
            else if (roll < 28)
                send_request(REQ_TICK, 16'($urandom));      // stray tick inside a round
            else
                send_request(REQ_CAPTURE, next_stamp());
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int kind;
        int cpr, pairs, span, ref_hz, limit;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero-length rounds, widest span, top reference, requests
        // while idle or settling and an ignored request kind
        write_config(0, 2, DAC_MAX, (1 << REF_W) - 1, 65535);
        send_request(REQ_CAPTURE, 16'hFFFF);   // idle: ignored
        send_request(REQ_TICK, 16'h0000);      // idle: ignored
        send_request(REQ_UNUSED, 16'hFFFF);    // idle: ignored
        send_request(REQ_START, 16'h0000);
        send_request(REQ_CAPTURE, 16'h1234);   // settling: ignored
        send_request(REQ_UNUSED, 16'h0000);
        send_request(REQ_TICK, 16'hFFFF);
        send_request(REQ_CAPTURE, 16'hFFFF);   // baseline alone ends the round
        send_request(REQ_TICK, 16'h0000);
        send_request(REQ_CAPTURE, 16'h0000);
        send_request(REQ_TICK, 16'h0000);
        send_request(REQ_CAPTURE, 16'h5555);
        send_request(REQ_TICK, 16'h0000);
        send_request(REQ_CAPTURE, 16'hAAAA);   // last round: zero totals in the final
        drain();

        // Directed: timestamp wrap inside a round, then the time limit expires
        write_config(2, 1, 1000, 16000000, 3);
        send_request(REQ_START, 16'hFFFF);
        send_request(REQ_TICK, 16'h0000);
        send_request(REQ_CAPTURE, 16'hFFF0);
        send_request(REQ_CAPTURE, 16'h0010);
        send_request(REQ_CAPTURE, 16'h0000);
        send_request(REQ_TICK, 16'h0000);
        send_request(REQ_TICK, 16'h0000);
        drain();

        // Directed: no round pairs finishes at once; zero limit aborts at once
        write_config(5, 0, 0, 0, 10);
        send_request(REQ_START, 16'h0000);
        drain();
        write_config(5, 1, 2048, 1, 0);
        send_request(REQ_START, 16'h0000);
        drain();

        // Random phases, each with its own register set
        while (requests_sent < TARGET_REQUESTS)
        begin
            kind   = $urandom_range(0, 9);
            cpr    = $urandom_range(0, 12);
            pairs  = $urandom_range(1, 3);
            span   = $urandom_range(0, DAC_MAX);
            ref_hz = $urandom_range(0, (1 << REF_W) - 1);
            limit  = $urandom_range(300, 2000);
            nominal_period = $urandom_range(1, 4000);
            phase_shift    = $urandom_range(0, 600) - 300;
            case (kind)
                0:
                begin
                    // rounds too long to finish: always ends on the limit
                    cpr   = $urandom_range(0, 1) ? 65535 : $urandom_range(1000, 65535);
                    limit = $urandom_range(1, 8);
                end
                1:
                begin
                    // many pairs, short periods: frequency saturates
                    pairs  = $urandom_range(0, 1) ? 255 : $urandom_range(4, 255);
                    ref_hz = (1 << REF_W) - 1;
                    limit  = $urandom_range(1, 30);
                    nominal_period = $urandom_range(0, 20);
                end
                2:
                begin
                    pairs = $urandom_range(0, 3);
                    limit = $urandom_range(0, 4);
                end
                3: cpr = $urandom_range(13, 40);
                4:
                begin
                    span   = $urandom_range(0, 1) ? 0 : DAC_MAX;
                    ref_hz = $urandom_range(0, 1) ? 0 : (1 << REF_W) - 1;
                end
                default: ;
            endcase
            steady_sender = (phases % 4 == 1);
            write_config(cpr, pairs, span, ref_hz, limit);

            // idle chatter before the first start
            repeat ($urandom_range(0, 3))
                send_request(2'($urandom_range(REQ_CAPTURE, REQ_UNUSED)), 16'($urandom));
            repeat ($urandom_range(1, 3))
                run_measurement();
            drain();
        end

        drain();
        $display("%0d requests sent, %0d effective, over %0d register sets, %0d results checked",
                 requests_sent, requests_applied, phases, sb.results_seen);
        $display("%0d measurements ran all rounds, %0d ended on the time limit",
                 sb.finals_ok, sb.finals_aborted);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("modulated_reciprocal_freq_counter_top: match");
        else
            $display("modulated_reciprocal_freq_counter_top: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
src/mrfc_pkg.sv
src/mrfc_ctrl.sv
src/mrfc_dpath.sv
src/modulated_reciprocal_freq_counter_top.sv
src/mrfc_checker.sv
verif/tb_modulated_reciprocal_freq_counter_top.sv
